// ===== design/rcrt_pkg.sv =====
package rcrt_pkg;

    localparam int SYMBOL_SLOTS_DEF = 16;
    localparam int STACK_FRAMES_DEF = 32;

    localparam logic [6:0] OPC_JAL  = 7'h6f;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_T0   = 5'd5;
    localparam logic [2:0] F3_JALR  = 3'd0;

    typedef enum logic [1:0] {
        CMD_RETIRE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CALL  = 3'd1,
        EV_MRET  = 3'd2,
        EV_URET  = 3'd3,
        EV_FULL  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SEARCH,
        S_FRAME,
        S_FCAP,
        S_PUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic        is_call;
        logic        is_ret;
        logic [31:0] link;
    } dec_t;

endpackage

// ===== design/rcrt_ram.sv =====
module rcrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rcrt_decode.sv =====
module rcrt_decode (
    input  logic [31:0]   pc,
    input  logic [31:0]   inst,
    input  logic [31:0]   next_pc,
    output rcrt_pkg::dec_t dec
);
    import rcrt_pkg::*;

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [2:0]  f3;
    logic [31:0] link;
    logic        is_jal;
    logic        is_jalr;
    logic        taken;

    always_comb
    begin
        opcode  = inst[6:0];
        rd      = inst[11:7];
        rs1     = inst[19:15];
        f3      = inst[14:12];
        link    = pc + 32'd4;
        taken   = (next_pc != link);
        is_jal  = (opcode == OPC_JAL);
        is_jalr = (opcode == OPC_JALR) && (f3 == F3_JALR);
        dec.link    = link;
        dec.is_call = (is_jal || is_jalr) && (rd == REG_RA || rd == REG_T0) && taken;
        dec.is_ret  = is_jalr && (rd == REG_ZERO) && (rs1 == REG_RA || rs1 == REG_T0)
                      && (inst[31:20] == 12'd0) && taken;
    end

endmodule

// ===== design/riscv_call_return_tracer_core.sv =====
// Call/return tracer with a shadow call stack, fed by retired instructions.
// Input channel (in_valid/in_stall): one beat per command: retire an
// instruction, load a symbol range into a slot, clear the call stack, or NOP.
// Output channel (out_valid/out_stall): exactly one result beat per input
// beat, in order. cfg_wr_en/cfg_wr_data write the active symbol count; write
// it only while the block is idle. A count of zero disables tracing.
// Loads, clears, NOPs and retirements that are neither call nor return, or
// that come with tracing off, go through S_DONE to the result register; the
// next beat is then taken back in S_IDLE. A call runs two symbol scans over
// the symbol RAM, then a push; the scans use the one range comparator over
// the registered-read symbol RAM. A return scans the frame RAM from the top,
// one frame per cycle, then runs both symbol scans when unmatched, one scan
// when it resumes the bottom frame, or a frame read through S_FRAME and
// S_FCAP otherwise.
// One item is in flight at a time; in_stall is high while it is worked on.
// A result held by out_stall blocks the finish of the next item only.
// Reset empties the stack and zeroes the symbol count; symbol and frame RAMs
// hold no reset value.
module riscv_call_return_tracer_core #(
    parameter int SYMBOL_SLOTS = rcrt_pkg::SYMBOL_SLOTS_DEF,
    parameter int STACK_FRAMES = rcrt_pkg::STACK_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] pc,
    input  logic [31:0] inst,
    input  logic [31:0] next_pc,
    input  logic [3:0]  symbol_slot,
    input  logic [31:0] symbol_start,
    input  logic [31:0] symbol_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [31:0] site_pc,
    output logic [31:0] link_pc,
    output logic [5:0]  pop_count,
    output logic        from_found,
    output logic [3:0]  from_index,
    output logic        to_found,
    output logic [3:0]  to_index,
    output logic [5:0]  stack_level
);
    import rcrt_pkg::*;

    localparam int SA = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
    localparam int IW = $clog2(SYMBOL_SLOTS + 1);
    localparam int FA = (STACK_FRAMES > 1) ? $clog2(STACK_FRAMES) : 1;
    localparam int DW = $clog2(STACK_FRAMES + 1);

    state_t      state_reg, state_next;
    logic [4:0]  count_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic        is_call_reg, is_call_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] tgt_reg, tgt_next;
    logic [31:0] link_reg, link_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] schk_reg, schk_next;
    logic [DW-1:0] ptr_reg, ptr_next;
    logic [DW-1:0] fchk_reg, fchk_next;
    logic        chk_valid_reg, chk_valid_next;
    logic        look_to_reg, look_to_next;
    event_t      ev_reg, ev_next;
    logic [5:0]  unw_reg, unw_next;
    logic        ff_reg, ff_next;
    logic [3:0]  fi_reg, fi_next;
    logic        tf_reg, tf_next;
    logic [3:0]  ti_reg, ti_next;

    logic        out_valid_reg;
    event_t      o_ev_reg;
    logic [31:0] o_site_reg, o_link_reg;
    logic [5:0]  o_unw_reg, o_level_reg;
    logic        o_ff_reg, o_tf_reg;
    logic [3:0]  o_fi_reg, o_ti_reg;

    dec_t        dec;
    logic        accept;
    logic        load_out;
    logic [IW-1:0] n_active;

    logic        sym_we;
    logic [SA-1:0] sym_waddr, sym_raddr;
    logic [63:0] sym_rdata;
    logic        frm_we;
    logic [FA-1:0] frm_waddr, frm_raddr;
    logic [36:0] frm_rdata;
    logic [DW-1:0] ptr_m1, depth_m1;

    logic [31:0] key;
    logic        sym_hit, look_hit, look_end;
    logic        frm_hit, srch_end;
    logic        room;

    rcrt_decode u_dec (
        .pc      (pc),
        .inst    (inst),
        .next_pc (next_pc),
        .dec     (dec)
    );

    rcrt_ram #(.WIDTH(64), .DEPTH(SYMBOL_SLOTS), .AW(SA)) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata ({symbol_start, symbol_end}),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    rcrt_ram #(.WIDTH(37), .DEPTH(STACK_FRAMES), .AW(FA)) u_frm_ram (
        .clk   (clk),
        .we    (frm_we),
        .waddr (frm_waddr),
        .wdata ({link_reg, tf_reg, ti_reg}),
        .raddr (frm_raddr),
        .rdata (frm_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (32'(count_reg) > SYMBOL_SLOTS)
        begin
            n_active = IW'(SYMBOL_SLOTS);
        end
        else
        begin
            n_active = IW'(count_reg);
        end
        ptr_m1    = ptr_reg - DW'(1);
        depth_m1  = depth_reg - DW'(1);
        room      = (32'(depth_reg) < STACK_FRAMES);
        key       = look_to_reg ? tgt_reg : pc_reg;
        sym_hit   = (key >= sym_rdata[63:32]) && (key < sym_rdata[31:0]);
        look_hit  = chk_valid_reg && sym_hit;
        look_end  = !chk_valid_reg && (idx_reg >= n_active);
        frm_hit   = chk_valid_reg && (frm_rdata[36:5] == tgt_reg);
        srch_end  = !chk_valid_reg && (ptr_reg == '0);
        sym_we    = accept && (cmd_t'(command) == CMD_LOAD)
                    && (32'(symbol_slot) < SYMBOL_SLOTS);
        sym_waddr = SA'(symbol_slot);
        sym_raddr = idx_reg[SA-1:0];
        frm_we    = (state_reg == S_PUSH) && room;
        frm_waddr = depth_reg[FA-1:0];
        frm_raddr = (state_reg == S_FRAME) ? depth_m1[FA-1:0] : ptr_m1[FA-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(command) == CMD_RETIRE && count_reg != '0 && dec.is_call)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (cmd_t'(command) == CMD_RETIRE && count_reg != '0 && dec.is_ret)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOOK:
            begin
                if ((look_hit || look_end) && look_to_reg)
                begin
                    state_next = is_call_reg ? S_PUSH : S_DONE;
                end
            end
            S_SEARCH:
            begin
                if (frm_hit)
                begin
                    state_next = (fchk_reg != '0) ? S_FRAME : S_LOOK;
                end
                else if (srch_end)
                begin
                    state_next = S_LOOK;
                end
            end
            S_FRAME: state_next = S_FCAP;
            S_FCAP:  state_next = S_DONE;
            S_PUSH:  state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        depth_next     = depth_reg;
        is_call_next   = is_call_reg;
        pc_next        = pc_reg;
        tgt_next       = tgt_reg;
        link_next      = link_reg;
        idx_next       = idx_reg;
        schk_next      = schk_reg;
        ptr_next       = ptr_reg;
        fchk_next      = fchk_reg;
        chk_valid_next = chk_valid_reg;
        look_to_next   = look_to_reg;
        ev_next        = ev_reg;
        unw_next       = unw_reg;
        ff_next        = ff_reg;
        fi_next        = fi_reg;
        tf_next        = tf_reg;
        ti_next        = ti_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pc_next        = pc;
                    tgt_next       = next_pc;
                    link_next      = dec.link;
                    is_call_next   = dec.is_call;
                    ev_next        = EV_NONE;
                    unw_next       = '0;
                    ff_next        = 1'b0;
                    fi_next        = '0;
                    tf_next        = 1'b0;
                    ti_next        = '0;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                    look_to_next   = 1'b0;
                    ptr_next       = depth_reg;
                    if (cmd_t'(command) == CMD_CLEAR)
                    begin
                        depth_next = '0;
                    end
                end
            end
            S_LOOK:
            begin
                // issue one slot per cycle, compare the one read last cycle
                if (idx_reg < n_active)
                begin
                    idx_next       = idx_reg + IW'(1);
                    schk_next      = idx_reg;
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (look_hit || look_end)
                begin
                    if (look_to_reg)
                    begin
                        tf_next = look_hit;
                        ti_next = look_hit ? 4'(schk_reg) : 4'd0;
                    end
                    else
                    begin
                        ff_next = look_hit;
                        fi_next = look_hit ? 4'(schk_reg) : 4'd0;
                    end
                    look_to_next   = 1'b1;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                end
            end
            S_SEARCH:
            begin
                // walk frames from the top down
                if (ptr_reg != '0)
                begin
                    ptr_next       = ptr_m1;
                    fchk_next      = ptr_m1;
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (frm_hit)
                begin
                    ev_next        = EV_MRET;
                    unw_next       = 6'(depth_reg - fchk_reg);
                    depth_next     = fchk_reg;
                    ff_next        = frm_rdata[4];
                    fi_next        = frm_rdata[3:0];
                    look_to_next   = 1'b1;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                end
                else if (srch_end)
                begin
                    ev_next        = EV_URET;
                    unw_next       = 6'(depth_reg);
                    depth_next     = '0;
                    look_to_next   = 1'b0;
                    idx_next       = '0;
                    chk_valid_next = 1'b0;
                end
            end
            S_FRAME:
            begin
            end
            S_FCAP:
            begin
                tf_next = frm_rdata[4];
                ti_next = frm_rdata[3:0];
            end
            S_PUSH:
            begin
                if (room)
                begin
                    depth_next = depth_reg + DW'(1);
                    ev_next    = EV_CALL;
                end
                else
                begin
                    ev_next = EV_FULL;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            depth_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            chk_valid_reg <= chk_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_call_reg <= is_call_next;
        pc_reg      <= pc_next;
        tgt_reg     <= tgt_next;
        link_reg    <= link_next;
        idx_reg     <= idx_next;
        schk_reg    <= schk_next;
        ptr_reg     <= ptr_next;
        fchk_reg    <= fchk_next;
        look_to_reg <= look_to_next;
        ev_reg      <= ev_next;
        unw_reg     <= unw_next;
        ff_reg      <= ff_next;
        fi_reg      <= fi_next;
        tf_reg      <= tf_next;
        ti_reg      <= ti_next;
        if (load_out)
        begin
            o_ev_reg    <= ev_reg;
            o_site_reg  <= (ev_reg == EV_NONE) ? 32'd0 : pc_reg;
            o_link_reg  <= (ev_reg == EV_NONE) ? 32'd0 :
                           (ev_reg == EV_CALL || ev_reg == EV_FULL) ? link_reg : tgt_reg;
            o_unw_reg   <= unw_reg;
            o_ff_reg    <= ff_reg;
            o_fi_reg    <= fi_reg;
            o_tf_reg    <= tf_reg;
            o_ti_reg    <= ti_reg;
            o_level_reg <= 6'(depth_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = o_ev_reg;
    assign site_pc      = o_site_reg;
    assign link_pc      = o_link_reg;
    assign pop_count    = o_unw_reg;
    assign from_found   = o_ff_reg;
    assign from_index   = o_fi_reg;
    assign to_found     = o_tf_reg;
    assign to_index     = o_ti_reg;
    assign stack_level  = o_level_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= STACK_FRAMES)
        else $error("stack depth above frame count");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && room) |=> depth_reg == $past(depth_reg) + DW'(1))
        else $error("push did not grow the stack");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_t'(command) == CMD_CLEAR) |=> depth_reg == '0)
        else $error("clear left frames on the stack");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && look_hit) |-> schk_reg < n_active)
        else $error("symbol hit beyond active slots");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> state_reg == S_IDLE && out_valid_reg)
        else $error("result not presented after finish");

endmodule

// ===== sim/tb_riscv_call_return_tracer_core.sv =====
module tb_riscv_call_return_tracer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rcrt_pkg::*;

    localparam int SLOTS = 16;
    localparam int FRAMES = 32;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] pc;
        logic [31:0] inst;
        logic [31:0] nxt;
        logic [3:0]  slot;
        logic [31:0] sym_lo;
        logic [31:0] sym_hi;
    } beat_t;

    typedef struct {
        event_t      ev;
        logic [31:0] site;
        logic [31:0] link;
        logic [5:0]  unwind;
        logic        from_ok;
        logic [3:0]  from_idx;
        logic        to_ok;
        logic [3:0]  to_idx;
        logic [5:0]  level;
    } trace_t;

    class trace_board;
        logic [31:0] sym_lo [SLOTS];
        logic [31:0] sym_hi [SLOTS];
        logic [31:0] ret_addr [FRAMES];
        logic [4:0]  callee [FRAMES];
        int          depth;
        int          sym_count;
        trace_t      pending[$];
        int          errors;
        int          seen [5];

        function new();
            depth = 0;
            sym_count = 0;
            errors = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        // 0 when no range holds addr, else slot + 1
        function logic [4:0] find_sym(logic [31:0] addr);
            int n;
            n = sym_count > SLOTS ? SLOTS : sym_count;
            for (int i = 0; i < n; i++)
                if (addr >= sym_lo[i] && addr < sym_hi[i]) return 5'(i + 1);
            return 5'd0;
        endfunction

        function void put_from(ref trace_t r, input logic [4:0] s);
            r.from_ok = s != 0;
            r.from_idx = s != 0 ? 4'(s - 1) : 4'd0;
        endfunction

        function void put_to(ref trace_t r, input logic [4:0] s);
            r.to_ok = s != 0;
            r.to_idx = s != 0 ? 4'(s - 1) : 4'd0;
        endfunction

        function void note_beat(beat_t b);
            trace_t r;
            logic [6:0]  opc;
            logic [4:0]  rd, rs1;
            logic [2:0]  f3;
            logic [31:0] link;
            logic [4:0]  cs;
            bit          jal, jalr, call, ret, hit;
            int          m;
            r = '{EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0};
            if (b.cmd == CMD_LOAD) begin
                sym_lo[b.slot] = b.sym_lo;
                sym_hi[b.slot] = b.sym_hi;
            end else if (b.cmd == CMD_CLEAR) begin
                depth = 0;
            end else if (b.cmd == CMD_RETIRE && sym_count != 0) begin
                opc = b.inst[6:0];
                rd = b.inst[11:7];
                f3 = b.inst[14:12];
                rs1 = b.inst[19:15];
                link = b.pc + 32'd4;
                jal = opc == OPC_JAL;
                jalr = opc == OPC_JALR && f3 == F3_JALR;
                call = (jal || jalr) && (rd == REG_RA || rd == REG_T0) && b.nxt != link;
                ret = jalr && rd == REG_ZERO && (rs1 == REG_RA || rs1 == REG_T0)
                      && b.inst[31:20] == 0 && b.nxt != link;
                if (call) begin
                    cs = find_sym(b.nxt);
                    r.site = b.pc;
                    r.link = link;
                    put_from(r, find_sym(b.pc));
                    put_to(r, cs);
                    if (depth < FRAMES) begin
                        ret_addr[depth] = link;
                        callee[depth] = cs;
                        depth++;
                        r.ev = EV_CALL;
                    end else begin
                        r.ev = EV_FULL;
                    end
                end else if (ret) begin
                    hit = 0;
                    m = 0;
                    for (int i = depth - 1; i >= 0; i--)
                        if (!hit && ret_addr[i] == b.nxt) begin
                            hit = 1;
                            m = i;
                        end
                    r.site = b.pc;
                    r.link = b.nxt;
                    if (!hit) begin
                        r.ev = EV_URET;
                        r.unwind = 6'(depth);
                        put_from(r, find_sym(b.pc));
                        put_to(r, find_sym(b.nxt));
                        depth = 0;
                    end else begin
                        r.ev = EV_MRET;
                        r.unwind = 6'(depth - m);
                        put_from(r, callee[m]);
                        put_to(r, m > 0 ? callee[m - 1] : find_sym(b.nxt));
                        depth = m;
                    end
                end
            end
            r.level = 6'(depth);
            pending.insert(pending.size(), r);
        endfunction

        function void fail(string f, logic [31:0] e, logic [31:0] a);
            $display("%0t: mismatch %s expected %h actual %h", $time, f, e, a);
            errors++;
        endfunction

        function void check_result(trace_t a);
            trace_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result event %0d site %h", $time, a.ev, a.site);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.ev < 5) seen[a.ev]++;
            if (a.ev !== e.ev) fail("event_res", e.ev, a.ev);
            if (a.site !== e.site) fail("site_pc", e.site, a.site);
            if (a.link !== e.link) fail("link_pc", e.link, a.link);
            if (a.unwind !== e.unwind) fail("pop_count", e.unwind, a.unwind);
            if (a.from_ok !== e.from_ok) fail("from_found", e.from_ok, a.from_ok);
            if (a.from_idx !== e.from_idx) fail("from_index", e.from_idx, a.from_idx);
            if (a.to_ok !== e.to_ok) fail("to_found", e.to_ok, a.to_ok);
            if (a.to_idx !== e.to_idx) fail("to_index", e.to_idx, a.to_idx);
            if (a.level !== e.level) fail("stack_level", e.level, a.level);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [4:0]  cfg_wr_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  command = 0;
    logic [31:0] pc = 0, inst = 0, next_pc = 0;
    logic [3:0]  symbol_slot = 0;
    logic [31:0] symbol_start = 0, symbol_end = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  event_res;
    logic [31:0] site_pc, link_pc;
    logic [5:0]  pop_count, stack_level;
    logic        from_found, to_found;
    logic [3:0]  from_index, to_index;

    riscv_call_return_tracer_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .command(command), .pc(pc),
        .inst(inst), .next_pc(next_pc), .symbol_slot(symbol_slot),
        .symbol_start(symbol_start), .symbol_end(symbol_end),
        .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
        .site_pc(site_pc), .link_pc(link_pc), .pop_count(pop_count),
        .from_found(from_found), .from_index(from_index), .to_found(to_found),
        .to_index(to_index), .stack_level(stack_level)
    );

    trace_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_req = 0;
    int hold_cnt = 0;
    int cycles = 0;
    int beats_sent = 0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt < 400) hold_cnt++;
        out_stall <= (hold_req && hold_cnt < 400) || ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result('{event_t'(event_res), site_pc, link_pc, pop_count,
                                 from_found, from_index, to_found, to_index, stack_level});
    end

    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        command <= b.cmd;
        pc <= b.pc;
        inst <= b.inst;
        next_pc <= b.nxt;
        symbol_slot <= b.slot;
        symbol_start <= b.sym_lo;
        symbol_end <= b.sym_hi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_beat(b);
        beats_sent++;
        // drop valid; the block stalls for at least this cycle anyway
        in_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_count(logic [4:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        board.sym_count = v;
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 32'h0001_0000 + ($urandom_range(32'hffff) & ~32'h3);
        if (r < 80) return 32'hffff_f000 + ($urandom_range(32'hfff) & ~32'h3);
        return $urandom();
    endfunction

    function automatic beat_t mk(cmd_t c, logic [31:0] a, logic [31:0] w, logic [31:0] n);
        beat_t b;
        b.cmd = c;
        b.pc = a;
        b.inst = w;
        b.nxt = n;
        b.slot = 4'($urandom());
        b.sym_lo = $urandom();
        b.sym_hi = $urandom();
        return b;
    endfunction

    function automatic logic [31:0] jal_w(logic [4:0] rd);
        return {20'($urandom_range(20'hfffff)), rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] jalr_w(logic [4:0] rd, logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, F3_JALR, rd, OPC_JALR};
    endfunction

    function automatic beat_t load_beat(int s, bit scramble);
        beat_t b;
        b = mk(CMD_LOAD, $urandom(), $urandom(), $urandom());
        b.slot = 4'(s);
        if (!scramble) begin
            b.sym_lo = 32'h0001_0000 + 32'(s) * 32'h1000;
            b.sym_hi = b.sym_lo + 32'h1000;
            if (s == 7) b.sym_hi = 32'h0002_0000;
            if (s == 14) begin
                b.sym_lo = 32'd0;
                b.sym_hi = 32'h100;
            end
            if (s == 15) begin
                b.sym_lo = 32'hffff_f000;
                b.sym_hi = 32'hffff_ffff;
            end
        end
        return b;
    endfunction

    function automatic beat_t call_beat();
        logic [31:0] a;
        a = pick_addr();
        if ($urandom_range(1)) return mk(CMD_RETIRE, a, jal_w($urandom_range(1) ? REG_RA : REG_T0),
                                         pick_addr());
        return mk(CMD_RETIRE, a, jalr_w($urandom_range(1) ? REG_RA : REG_T0, 5'($urandom()),
                  12'($urandom())), pick_addr());
    endfunction

    function automatic beat_t ret_beat(bit matched);
        logic [31:0] t;
        t = pick_addr();
        if (matched && board.depth > 0)
            t = board.ret_addr[$urandom_range(board.depth - 1)];
        return mk(CMD_RETIRE, pick_addr(),
                  jalr_w(REG_ZERO, $urandom_range(1) ? REG_RA : REG_T0, 12'd0), t);
    endfunction

    function automatic beat_t random_beat(int call_pct);
        int r;
        beat_t b;
        r = $urandom_range(99);
        if (r < call_pct) return call_beat();
        r = $urandom_range(99);
        if (r < 55) return ret_beat(1);
        if (r < 63) return ret_beat(0);
        if (r < 73) return mk(CMD_RETIRE, pick_addr(), $urandom(), pick_addr());
        if (r < 80) begin
            b = call_beat();
            b.nxt = b.pc + 32'd4;
            return b;
        end
        if (r < 84) begin
            b = ret_beat(1);
            b.inst[31:20] = 12'($urandom_range(1, 12'hfff));
            return b;
        end
        if (r < 88) begin
            b = call_beat();
            b.inst[14:12] = 3'($urandom_range(1, 7));
            return b;
        end
        if (r < 92) return mk(CMD_CLEAR, $urandom(), $urandom(), $urandom());
        if (r < 95) return mk(CMD_NOP, $urandom(), $urandom(), $urandom());
        return load_beat($urandom_range(SLOTS - 1), 1'($urandom_range(1)));
    endfunction

    task automatic run_phase(int n, int call_pct, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) send_beat(random_beat(call_pct));
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // tracing off: loads, then a call that must be ignored
        for (int s = 0; s < SLOTS; s++) send_beat(load_beat(s, 0));
        send_beat(mk(CMD_RETIRE, 32'h0001_0010, jal_w(REG_RA), 32'h0001_2000));
        drain();
        write_count(5'd16);
        send_beat(mk(CMD_RETIRE, 32'h0001_0010, jal_w(REG_RA), 32'h0001_2000));
        send_beat(mk(CMD_RETIRE, 32'h0001_2008, jalr_w(REG_T0, 5'd9, 12'h7ff), 32'h0001_3000));
        send_beat(mk(CMD_RETIRE, 32'hffff_fffc, jal_w(REG_RA), 32'h0000_0040));
        send_beat(mk(CMD_RETIRE, 32'h0000_0040, jalr_w(REG_ZERO, REG_RA, 12'd0), 32'h0));
        send_beat(mk(CMD_RETIRE, 32'h0001_3010, jalr_w(REG_ZERO, REG_T0, 12'd0), 32'h0001_0014));
        send_beat(mk(CMD_RETIRE, 32'h0001_0020, jalr_w(REG_ZERO, REG_RA, 12'd0), 32'h1234_5678));
        send_beat(mk(CMD_RETIRE, 32'h0001_0020, jalr_w(REG_RA, 5'd2, 12'd0), 32'h0001_0024));
        send_beat(mk(CMD_RETIRE, 32'h0001_0030, jalr_w(REG_ZERO, REG_RA, 12'h004), 32'h0001_0900));
        send_beat(mk(CMD_RETIRE, 32'h0001_0040, 32'hffff_ffff, 32'hffff_ffff));
        send_beat(mk(CMD_RETIRE, 32'h0001_0010, jal_w(REG_RA), 32'h0001_2000));
        send_beat(mk(CMD_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_beat(mk(CMD_NOP, 0, 0, 0));
        drain();

        // fill the stack past its depth, then unwind
        write_count(5'd31);
        run_phase(120, 85, 0, 0);
        write_count(5'd0);
        run_phase(40, 40, 88, 0);
        write_count(5'd1);
        run_phase(110, 45, 0, 88);
        write_count(5'd8);
        run_phase(110, 45, 36, 36);

        write_count(5'd16);
        send_idle = 0;
        recv_stall = 0;
        hold_req = 1;
        repeat (60) send_beat(random_beat(50));
        for (int i = 0; i < 40; i++) begin
            send_beat(random_beat(50));
            if (i % 10 == 0) while (board.pending.size() != 0) @(posedge clk);
        end
        drain();
        run_phase(150, 55, 88, 88);
        run_phase(150, 45, 0, 0);

        $display("sent %0d beats: %0d none, %0d calls, %0d matched returns", beats_sent,
                 board.seen[EV_NONE], board.seen[EV_CALL], board.seen[EV_MRET]);
        $display("%0d unmatched returns, %0d calls dropped on a full stack",
                 board.seen[EV_URET], board.seen[EV_FULL]);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
